// ===== sv/dfnco_pkg.sv =====
// Package for the dithered three-phase FSK synthesizer: payload types, codes,
// the quarter-wave sine table, the band modulo table and sample helpers.
// No dependencies; the RAM and the synthesizer import it.
package dfnco_pkg;

  // Request codes carried in req_type
  localparam logic [1:0] REQ_TICK      = 2'd0;
  localparam logic [1:0] REQ_START     = 2'd1;
  localparam logic [1:0] REQ_LOAD_SYM  = 2'd2;
  localparam logic [1:0] REQ_LOAD_BAND = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE_STEP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_GREEN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_BLUE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_ENABLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_COUNT   = 3'd4;

  // Sine table geometry
  localparam int SINE_ADDR_BITS  = 10;
  localparam int SINE_DEPTH      = 2 ** SINE_ADDR_BITS;
  localparam int QTR_BITS        = SINE_ADDR_BITS - 2;
  localparam int SINE_QTR        = 2 ** QTR_BITS;
  localparam int PH_DITHER_SHIFT = 32 - SINE_ADDR_BITS;
  localparam logic [14:0] SINE_PEAK   = 15'h7EFF;
  localparam logic [63:0] TWO_PI_Q60  = 64'h6487ED5110B4611A;

  // LCG constants; the two-step form advances the recurrence two steps at once
  localparam logic [63:0] LCG_MUL   = 64'd6364136223846793005;
  localparam logic [63:0] LCG_MUL2  = 64'(LCG_MUL * LCG_MUL);
  localparam logic [63:0] LCG_INC2  = LCG_MUL + 64'd1;
  localparam logic [31:0] LCG_A2_LO = LCG_MUL2[31:0];
  localparam logic [31:0] LCG_A2_HI = LCG_MUL2[63:32];

  // Output quantizer
  localparam logic [16:0] QUANT_BIAS  = 17'h07F00;
  localparam logic [7:0]  IDLE_SAMPLE = 8'h80;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  entry_index;
    logic [63:0] entry_value;
  } dfnco_in_t;

  typedef struct packed {
    logic [7:0] red_sample;
    logic [7:0] green_sample;
    logic [7:0] blue_sample;
    logic       sending;
  } dfnco_out_t;

  typedef logic [14:0] qtr_rom_t [SINE_QTR];
  typedef logic [3:0]  band_mod_t [256];

  // (a * b) >> 60 in Q60
  function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // Quotient a / d by shift and subtract, for small divisors at elaboration
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] d);
    logic [63:0] q, rem;
    q = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], a[b]};
      if (rem >= d) begin
        rem = rem - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // trunc(sin(2*pi*k/SINE_DEPTH) * peak) by a fixed-point Taylor series
  function automatic logic [14:0] quarter_sine(input int unsigned k);
    logic [63:0] kk, x, x2, term, sum, scaled;
    kk = 64'(k);
    x = (TWO_PI_Q60 >> SINE_ADDR_BITS) * kk
      + (((TWO_PI_Q60 & 64'(SINE_DEPTH - 1)) * kk) >> SINE_ADDR_BITS);
    x2 = q60_mul(x, x);
    term = x;
    sum = x;
    for (int n = 1; n <= 12; n++) begin
      term = udiv64(q60_mul(term, x2), 64'((2 * n) * (2 * n + 1)));
      if ((n & 1) == 1) sum = sum - term;
      else sum = sum + term;
    end
    scaled = ((sum >> 20) * 64'(SINE_PEAK)) >> 40;
    return scaled[14:0];
  endfunction

  function automatic qtr_rom_t build_qtr_rom();
    qtr_rom_t rom;
    for (int i = 0; i < SINE_QTR; i++) rom[i] = quarter_sine(i);
    return rom;
  endfunction

  localparam qtr_rom_t QTR_ROM = build_qtr_rom();

  // Entry {a-1, c-1} holds a % c for a, c in 1..16
  function automatic band_mod_t build_band_mod();
    band_mod_t t;
    int a, c;
    for (int i = 0; i < 256; i++) begin
      a = (i >> 4) + 1;
      c = (i & 15) + 1;
      while (a >= c) a = a - c;
      t[i] = 4'(a);
    end
    return t;
  endfunction

  localparam band_mod_t BAND_MOD = build_band_mod();

  // Full-wave sine from the quarter table
  function automatic logic [15:0] sine_lookup(input logic [SINE_ADDR_BITS-1:0] addr);
    logic [QTR_BITS-1:0] r;
    logic [QTR_BITS-1:0] r_mirror;
    logic [14:0] mag;
    logic [15:0] val;
    r = addr[QTR_BITS-1:0];
    r_mirror = ~r + QTR_BITS'(1);
    if (addr[QTR_BITS]) mag = (r == '0) ? SINE_PEAK : QTR_ROM[r_mirror];
    else mag = QTR_ROM[r];
    val = {1'b0, mag};
    return addr[SINE_ADDR_BITS-1] ? (~val + 16'd1) : val;
  endfunction

  // Add bias and dither byte, keep the high byte
  function automatic logic [7:0] quantize(input logic [15:0] s, input logic [7:0] d);
    logic [16:0] sum;
    sum = QUANT_BIAS + {s[15], s} + {9'd0, d};
    return sum[15:8];
  endfunction

endpackage

// ===== sv/dfnco_stream_if.sv =====
// Valid/ready stream channel with a typed payload.
// Payload types come from dfnco_pkg.
interface dfnco_stream_if #(
  parameter type payload_t = logic [0:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/dfnco_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Uses dfnco_pkg only by convention; no other dependencies.
module dfnco_ram
  import dfnco_pkg::*;
#(
  parameter int WIDTH = 2,
  parameter int DEPTH = 162,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and read-first registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/dithered_fsk_nco_three_phase.sv =====
// Three-output 4-FSK synthesizer with phase and amplitude dither.
// A sample tick passes stages 1 to 4 and the output register before its result shows.
// Throughput: one item per clock while out_chan is ready; carrier phase, symbol clock
// and LCG advance per tick (the LCG runs a two-step lookahead with registered products).
// Reset (rst_n low, synchronous) clears control state and configuration; the
// symbol store and band table hold unknown data until loaded, with no clear pass.
module dithered_fsk_nco_three_phase
  import dfnco_pkg::*;
#(
  parameter int SYMBOL_COUNT = 162,
  parameter int MAX_BANDS    = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_wdata,
  dfnco_stream_if.sink         in_chan,
  dfnco_stream_if.source       out_chan
);

  localparam int SYM_AW  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int BAND_IW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;

  // Configuration registers
  logic [63:0] tone_step_r, tone_step3_r, shift_green_r, shift_blue_r;
  logic        swap_en_r;
  logic [4:0]  band_count_r;

  // Transmission state
  logic [63:0] phase_r, inc_r, sclk_r, band_word_r;
  logic [63:0] phase_nxt, inc_nxt, sclk_nxt, band_word_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [BAND_IW-1:0] next_band_r, next_band_nxt;
  logic        active_r, active_nxt, swapped_r, swapped_nxt;
  logic [63:0] band_tbl_r [MAX_BANDS];

  // LCG lookahead
  logic [63:0] rng_head_r, rng_next_r, rng_pp0_r, rng_step2;
  logic [31:0] rng_pp1_r, rng_pp2_r, rng_cross;

  // Input decode
  logic [1:0]  req;
  logic [7:0]  idx;
  logic [63:0] val;
  logic in_acc, tick_acc, start_acc, sym_we, band_we;

  // Symbol store access
  logic [SYM_AW-1:0] sym_rd_addr;
  logic [8:0]        rd_next;
  logic [1:0]        ram_q, sym_rd, byp_data_r;
  logic              byp_hit_r;
  logic [63:0]       sym_step, band_sel;
  logic [64:0]       sclk_sum;
  logic [8:0]        pos_inc;
  logic [4:0]        cnt_eff;

  // Pipeline
  logic ld1, ld2, ld3, ld4, ld_out;
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, out_vld_r;
  logic s1_act_r, s2_act_r, s3_act_r, s4_act_r;
  logic [63:0] s1_phase_r, s1_g_r, s1_b_r, s2_ph_r, s2_g_r, s2_b_r;
  logic [31:0] s1_rnd_r;
  logic [23:0] s2_dith_r, s3_dith_r, s4_dith_r;
  logic [63:0] s3_sum_g, s3_sum_b;
  logic [SINE_ADDR_BITS-1:0] s3_addr_r_r, s3_addr_g_r, s3_addr_b_r;
  logic [15:0] s4_red_r, s4_green_r, s4_blue_r;
  dfnco_out_t  out_r;

  assign req = in_chan.payload.req_type;
  assign idx = in_chan.payload.entry_index;
  assign val = in_chan.payload.entry_value;

  assign in_acc    = in_chan.valid && in_chan.ready;
  assign tick_acc  = in_acc && (req == REQ_TICK);
  assign start_acc = in_acc && (req == REQ_START) && !active_r;
  assign sym_we    = in_acc && (req == REQ_LOAD_SYM) && (idx < 8'(SYMBOL_COUNT));
  assign band_we   = in_acc && (req == REQ_LOAD_BAND) && (idx < 8'(MAX_BANDS));

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_step_r   <= '0;
      tone_step3_r  <= '0;
      shift_green_r <= '0;
      shift_blue_r  <= '0;
      swap_en_r     <= 1'b0;
      band_count_r  <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TONE_STEP: begin
          tone_step_r  <= cfg_wdata;
          tone_step3_r <= cfg_wdata + {cfg_wdata[62:0], 1'b0};
        end
        CFG_SHIFT_GREEN: shift_green_r <= cfg_wdata;
        CFG_SHIFT_BLUE:  shift_blue_r  <= cfg_wdata;
        CFG_SWAP_ENABLE: swap_en_r     <= cfg_wdata[0];
        CFG_BAND_COUNT:  band_count_r  <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // Symbol store with a bypass for a write to the address read in the same cycle
  dfnco_ram #(
    .WIDTH (2),
    .DEPTH (SYMBOL_COUNT)
  ) u_sym_ram (
    .clk     (clk),
    .wr_en   (sym_we),
    .wr_addr (SYM_AW'(idx)),
    .wr_data (val[1:0]),
    .rd_addr (sym_rd_addr),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) byp_hit_r <= 1'b0;
    else byp_hit_r <= sym_we && (SYM_AW'(idx) == sym_rd_addr);
    byp_data_r <= val[1:0];
  end

  assign sym_rd = byp_hit_r ? byp_data_r : ram_q;

  // Prefetch the symbol after the current one, or symbol zero while idle
  always_comb begin
    rd_next = active_nxt ? (9'(pos_nxt) + 9'd1) : 9'd0;
    sym_rd_addr = (rd_next < 9'(SYMBOL_COUNT)) ? SYM_AW'(rd_next) : '0;
  end

  // Tone offset: tone_step times the 2-bit symbol
  always_comb begin
    unique case (sym_rd)
      2'd0: sym_step = '0;
      2'd1: sym_step = tone_step_r;
      2'd2: sym_step = {tone_step_r[62:0], 1'b0};
      default: sym_step = tone_step3_r;
    endcase
  end

  // Clamp band count to 1..MAX_BANDS
  always_comb begin
    if (band_count_r == 5'd0) cnt_eff = 5'd1;
    else if (band_count_r > 5'(MAX_BANDS)) cnt_eff = 5'(MAX_BANDS);
    else cnt_eff = band_count_r;
  end

  // Start, carrier advance and symbol clock
  always_comb begin
    phase_nxt     = phase_r;
    inc_nxt       = inc_r;
    sclk_nxt      = sclk_r;
    pos_nxt       = pos_r;
    band_word_nxt = band_word_r;
    next_band_nxt = next_band_r;
    active_nxt    = active_r;
    swapped_nxt   = swapped_r;
    band_sel      = band_tbl_r[next_band_r];
    sclk_sum      = {1'b0, sclk_r} + {1'b0, tone_step_r};
    pos_inc       = 9'(pos_r) + 9'd1;
    if (start_acc) begin
      pos_nxt       = '0;
      sclk_nxt      = '0;
      phase_nxt     = '0;
      band_word_nxt = band_sel;
      inc_nxt       = band_sel + sym_step;
      next_band_nxt = BAND_IW'(BAND_MOD[{4'(next_band_r), 4'(cnt_eff - 5'd1)}]);
      if (swap_en_r) swapped_nxt = !swapped_r;
      active_nxt = 1'b1;
    end else if (tick_acc && active_r) begin
      phase_nxt = phase_r + inc_r;
      sclk_nxt  = sclk_sum[63:0];
      if (sclk_sum[64]) begin
        pos_nxt = pos_inc[7:0];
        if (pos_inc < 9'(SYMBOL_COUNT)) inc_nxt = band_word_r + sym_step;
        else active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      inc_r       <= '0;
      sclk_r      <= '0;
      pos_r       <= '0;
      band_word_r <= '0;
      next_band_r <= '0;
      active_r    <= 1'b0;
      swapped_r   <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      inc_r       <= inc_nxt;
      sclk_r      <= sclk_nxt;
      pos_r       <= pos_nxt;
      band_word_r <= band_word_nxt;
      next_band_r <= next_band_nxt;
      active_r    <= active_nxt;
      swapped_r   <= swapped_nxt;
    end
  end

  // Band table
  always_ff @(posedge clk) begin
    if (band_we) band_tbl_r[BAND_IW'(idx)] <= val;
  end

  // LCG: head holds the next value, the products precompute two steps ahead
  assign rng_cross = rng_pp1_r + rng_pp2_r;
  assign rng_step2 = rng_pp0_r + {rng_cross, 32'd0} + LCG_INC2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rng_head_r <= 64'd1;
      rng_next_r <= LCG_INC2;
      rng_pp0_r  <= {32'd0, LCG_A2_LO};
      rng_pp1_r  <= LCG_A2_HI;
      rng_pp2_r  <= '0;
    end else if (tick_acc) begin
      rng_head_r <= rng_next_r;
      rng_next_r <= rng_step2;
      rng_pp0_r  <= {32'd0, rng_next_r[31:0]} * {32'd0, LCG_A2_LO};
      rng_pp1_r  <= rng_next_r[31:0] * LCG_A2_HI;
      rng_pp2_r  <= rng_next_r[63:32] * LCG_A2_LO;
    end
  end

  // Stage load enables, back to front
  assign ld_out = !out_vld_r || out_chan.ready;
  assign ld4    = !s4_vld_r || ld_out;
  assign ld3    = !s3_vld_r || ld4;
  assign ld2    = !s2_vld_r || ld3;
  assign ld1    = !s1_vld_r || ld2;

  assign in_chan.ready = ld1;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (ld1)    s1_vld_r  <= tick_acc;
      if (ld2)    s2_vld_r  <= s1_vld_r;
      if (ld3)    s3_vld_r  <= s2_vld_r;
      if (ld4)    s4_vld_r  <= s3_vld_r;
      if (ld_out) out_vld_r <= s4_vld_r;
    end
  end

  // Stage 1: capture advanced phase, random word and active offsets
  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_act_r   <= active_r;
      s1_phase_r <= phase_r + inc_r;
      s1_rnd_r   <= rng_head_r[63:32];
      s1_g_r     <= swapped_r ? shift_blue_r : shift_green_r;
      s1_b_r     <= swapped_r ? shift_green_r : shift_blue_r;
    end
  end

  // Stage 2: add phase dither
  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_act_r  <= s1_act_r;
      s2_ph_r   <= s1_phase_r + (64'(s1_rnd_r) << PH_DITHER_SHIFT);
      s2_g_r    <= s1_g_r;
      s2_b_r    <= s1_b_r;
      s2_dith_r <= s1_rnd_r[23:0];
    end
  end

  // Stage 3: apply offsets, keep the table addresses
  assign s3_sum_g = s2_ph_r + s2_g_r;
  assign s3_sum_b = s2_ph_r + s2_b_r;

  always_ff @(posedge clk) begin
    if (ld3) begin
      s3_act_r    <= s2_act_r;
      s3_addr_r_r <= s2_ph_r[63 -: SINE_ADDR_BITS];
      s3_addr_g_r <= s3_sum_g[63 -: SINE_ADDR_BITS];
      s3_addr_b_r <= s3_sum_b[63 -: SINE_ADDR_BITS];
      s3_dith_r   <= s2_dith_r;
    end
  end

  // Stage 4: sine lookup
  always_ff @(posedge clk) begin
    if (ld4) begin
      s4_act_r   <= s3_act_r;
      s4_red_r   <= sine_lookup(s3_addr_r_r);
      s4_green_r <= sine_lookup(s3_addr_g_r);
      s4_blue_r  <= sine_lookup(s3_addr_b_r);
      s4_dith_r  <= s3_dith_r;
    end
  end

  // Output: quantize with amplitude dither, or hold mid-scale when idle
  always_ff @(posedge clk) begin
    if (ld_out) begin
      if (s4_act_r) begin
        out_r.red_sample   <= quantize(s4_red_r, s4_dith_r[7:0]);
        out_r.green_sample <= quantize(s4_green_r, s4_dith_r[15:8]);
        out_r.blue_sample  <= quantize(s4_blue_r, s4_dith_r[23:16]);
        out_r.sending      <= 1'b1;
      end else begin
        out_r.red_sample   <= IDLE_SAMPLE;
        out_r.green_sample <= IDLE_SAMPLE;
        out_r.blue_sample  <= IDLE_SAMPLE;
        out_r.sending      <= 1'b0;
      end
    end
  end

  assign out_chan.valid   = out_vld_r;
  assign out_chan.payload = out_r;

  // A start from idle opens a transmission at symbol zero with phase cleared
  assert property (@(posedge clk) disable iff (!rst_n)
    start_acc |=> active_r && (pos_r == '0) && (phase_r == '0) && (sclk_r == '0))
    else $error("start did not open a transmission");

  // While sending, the symbol position stays inside the store
  assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (9'(pos_r) < 9'(SYMBOL_COUNT)))
    else $error("symbol position past last symbol");

  // Each tick moves the LCG lookahead by exactly one value
  assert property (@(posedge clk) disable iff (!rst_n)
    tick_acc |=> (rng_head_r == $past(rng_next_r)))
    else $error("LCG lookahead out of step");

  // An idle result carries mid-scale on all three outputs
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_r.sending) |-> (out_r.red_sample == IDLE_SAMPLE) &&
      (out_r.green_sample == IDLE_SAMPLE) && (out_r.blue_sample == IDLE_SAMPLE))
    else $error("idle sample not at mid-scale");

endmodule
